FILE: rtl/gradient_noise_2d_octaves_macros.svh
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves_macros
// Assertion macros shared by the noise block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_OCTAVES_MACROS_SVH
`define GRADIENT_NOISE_2D_OCTAVES_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define GN2O_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define GN2O_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gn2o_pkg.sv
// ----------------------------------------------------------------------------
// gn2o_pkg
// Types, constants and arithmetic helpers of the fractal gradient noise block.
// ----------------------------------------------------------------------------
package gn2o_pkg;

	localparam int TABLE_SIZE  = 256;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int FRAC_BITS   = 16;
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = $clog2(MAX_OCTAVES);
	localparam int COORD_W     = 24;
	localparam int OUT_W       = 19;
	localparam int CFG_W       = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0] OCT_RESET = 4'd4;
	localparam logic             KIND_LOAD = 1'b0;
	localparam logic             KIND_EVAL = 1'b1;

	// One queued item
	typedef struct packed {
		logic               kind;
		logic [IDX_W-1:0]   table_index;
		logic [IDX_W-1:0]   table_value;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// Gradient dot product for one corner, gradient chosen by two hash bits
	function automatic logic signed [18:0] corner_dot(input logic [1:0] h,
		input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [18:0] ex;
		logic signed [18:0] ey;
		logic signed [18:0] r;
		ex = 19'(dx);
		ey = 19'(dy);
		unique case (h)
			2'd0: r = ex + ey;
			2'd1: r = ey - ex;
			2'd2: r = ex - ey;
			default: r = -ex - ey;
		endcase
		return r;
	endfunction

	// a + floor((b - a) * w / ONE)
	function automatic logic signed [19:0] lerp_fx(input logic signed [19:0] a,
		input logic signed [19:0] b, input logic [16:0] w);
		logic signed [20:0] diff;
		logic signed [38:0] prod;
		logic signed [38:0] shr;
		diff = 21'(b) - 21'(a);
		prod = 39'(diff) * 39'($signed({1'b0, w}));
		shr  = prod >>> FRAC_BITS;
		return a + shr[19:0];
	endfunction

endpackage

FILE: rtl/gn2o_ram.sv
// ----------------------------------------------------------------------------
// gn2o_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gn2o_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read the storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/gn2o_front.sv
// ----------------------------------------------------------------------------
// gn2o_front
// Accepts input items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_octaves_macros.svh"

module gn2o_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gn2o_pkg::item_t      in_item,
	output gn2o_pkg::queue_head_t head,
	input  logic                 pop
);

	gn2o_pkg::item_t slot_q [gn2o_pkg::QUEUE_DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;

	assign in_stall  = (count_q == 2'(gn2o_pkg::QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	// Store an accepted item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`GN2O_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, count_q != 2'd0, "pop from empty queue")
	`GN2O_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= 2'd2, "queue count overflow")

endmodule

FILE: rtl/gn2o_back.sv
// ----------------------------------------------------------------------------
// gn2o_back
// Runs queued items: table loads and octave-by-octave noise evaluation.
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_octaves_macros.svh"

module gn2o_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gn2o_pkg::queue_head_t         head,
	output logic                          pop,
	input  logic [gn2o_pkg::CFG_W-1:0]    oct_cnt,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [gn2o_pkg::OUT_W-1:0] noise_value
);

	localparam int IW = gn2o_pkg::IDX_W;
	localparam int FB = gn2o_pkg::FRAC_BITS;
	localparam int OW = gn2o_pkg::OCT_W;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_FETCH0 = 7'b0000010,
		ST_FETCH1 = 7'b0000100,
		ST_FETCH2 = 7'b0001000,
		ST_BLEND0 = 7'b0010000,
		ST_BLEND1 = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [gn2o_pkg::COORD_W-1:0]    x_q, y_q;
	logic [OW-1:0]                   oct_q;
	logic [OW-1:0]                   oct_last;
	logic signed [21:0]              sum_q;
	logic                            out_valid_q;
	logic signed [gn2o_pkg::OUT_W-1:0] noise_q;

	logic [31:0]      xs, ys;
	logic [IW-1:0]    xi, yi, yn;
	logic [FB-1:0]    xf, yf;
	logic [IW-1:0]    px_q, pxn_q, h1_q, h2_q;
	logic [IW-1:0]    raddr_a, raddr_b;
	logic [IW-1:0]    rdata_a, rdata_b;
	logic             ram_we;
	logic             out_free;

	logic [31:0]      sqx, sqy, cbx, cby;
	logic [FB-1:0]    t2x_q, t2y_q, t3x_q, t3y_q;
	logic [21:0]      inx_q, iny_q;
	logic [37:0]      fdx, fdy;
	logic [16:0]      u_q, v_q;

	logic signed [17:0] dx, dy, dxm, dym;
	logic signed [19:0] l1_q, l2_q, g1, g2, g3, g4, nz;
	logic signed [19:0] term;

	// Clamp octave count to 1..MAX_OCTAVES, keep last index
	always_comb begin
		priority if (oct_cnt == '0) begin
			oct_last = '0;
		end else if (oct_cnt > gn2o_pkg::CFG_W'(gn2o_pkg::MAX_OCTAVES)) begin
			oct_last = OW'(gn2o_pkg::MAX_OCTAVES - 1);
		end else begin
			oct_last = OW'(oct_cnt - 1'b1);
		end
	end

	// Scale the point for the current octave
	assign xs = {8'b0, x_q} << oct_q;
	assign ys = {8'b0, y_q} << oct_q;
	assign xi = xs[FB +: IW];
	assign yi = ys[FB +: IW];
	assign yn = yi + 1'b1;
	assign xf = xs[FB-1:0];
	assign yf = ys[FB-1:0];

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign ram_we   = pop && (head.item.kind == gn2o_pkg::KIND_LOAD);

	// Select table read addresses
	always_comb begin
		unique case (state_q)
			ST_FETCH0: begin
				raddr_a = xi;
				raddr_b = xi + 1'b1;
			end
			ST_FETCH1: begin
				raddr_a = rdata_a + yi;
				raddr_b = rdata_b + yi;
			end
			default: begin
				raddr_a = px_q + yn;
				raddr_b = pxn_q + yn;
			end
		endcase
	end

	gn2o_ram #(
		.WIDTH(IW),
		.DEPTH(gn2o_pkg::TABLE_SIZE)
	) u_perm (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (head.item.table_index),
		.wdata  (head.item.table_value),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// Fade pipeline: square, cube and blend polynomial, each step registered
	assign sqx = 32'(xf) * 32'(xf);
	assign sqy = 32'(yf) * 32'(yf);
	assign cbx = 32'(t2x_q) * 32'(xf);
	assign cby = 32'(t2y_q) * 32'(yf);
	assign fdx = 38'(t3x_q) * 38'(inx_q);
	assign fdy = 38'(t3y_q) * 38'(iny_q);

	always_ff @(posedge clk) begin
		t2x_q <= sqx[FB +: FB];
		t2y_q <= sqy[FB +: FB];
		t3x_q <= cbx[FB +: FB];
		t3y_q <= cby[FB +: FB];
		inx_q <= 22'd655360 - 22'(20'd15 * 20'(xf)) + 22'(22'd6 * 22'(t2x_q));
		iny_q <= 22'd655360 - 22'(20'd15 * 20'(yf)) + 22'(22'd6 * 22'(t2y_q));
		u_q   <= fdx[FB +: 17];
		v_q   <= fdy[FB +: 17];
	end

	// Corner gradients and blends
	assign dx  = $signed({2'b0, xf});
	assign dy  = $signed({2'b0, yf});
	assign dxm = dx - 18'sd65536;
	assign dym = dy - 18'sd65536;
	assign g1  = 20'(gn2o_pkg::corner_dot(h1_q[1:0], dx, dy));
	assign g2  = 20'(gn2o_pkg::corner_dot(h2_q[1:0], dxm, dy));
	assign g3  = 20'(gn2o_pkg::corner_dot(rdata_a[1:0], dx, dym));
	assign g4  = 20'(gn2o_pkg::corner_dot(rdata_b[1:0], dxm, dym));
	assign nz  = gn2o_pkg::lerp_fx(l1_q, l2_q, v_q);
	assign term = nz >>> oct_q;

	// Hold lookups and first-level blends
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH1) begin
			px_q  <= rdata_a;
			pxn_q <= rdata_b;
		end
		if (state_q == ST_FETCH2) begin
			h1_q <= rdata_a;
			h2_q <= rdata_b;
		end
		l1_q <= gn2o_pkg::lerp_fx(g1, g2, u_q);
		l2_q <= gn2o_pkg::lerp_fx(g3, g4, u_q);
		if (pop) begin
			x_q <= head.item.x_coord;
			y_q <= head.item.y_coord;
		end
		if ((state_q == ST_DONE) && out_free) begin
			noise_q <= sum_q[gn2o_pkg::OUT_W-1:0];
		end
	end

	// Sequence octaves and drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oct_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.item.kind == gn2o_pkg::KIND_EVAL) begin
						oct_q   <= '0;
						sum_q   <= '0;
						state_q <= ST_FETCH0;
					end
				end
				ST_FETCH0: state_q <= ST_FETCH1;
				ST_FETCH1: state_q <= ST_FETCH2;
				ST_FETCH2: state_q <= ST_BLEND0;
				ST_BLEND0: state_q <= ST_BLEND1;
				ST_BLEND1: begin
					sum_q <= sum_q + 22'(term);
					if (oct_q == oct_last) begin
						state_q <= ST_DONE;
					end else begin
						oct_q   <= oct_q + 1'b1;
						state_q <= ST_FETCH0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;

	`GN2O_ASSERT_SAME(a_pop_idle, clk, arst_n, pop, state_q == ST_IDLE, "pop outside idle")
	`GN2O_ASSERT_NEXT(a_done_out, clk, arst_n, (state_q == ST_DONE) && out_free, out_valid_q, "result not presented")
	`GN2O_ASSERT_SAME(a_oct_range, clk, arst_n, state_q != ST_IDLE, oct_q <= oct_last, "octave past last")

endmodule

FILE: rtl/gradient_noise_2d_octaves.sv
// Load item: one per cycle through the queue and back end while the back end is idle; it
// writes the permutation table. Evaluate item with n octaves (octave_count held to 1..8):
// the back end pops it in idle, steps through fetch0, fetch1, fetch2, blend0 and blend1 per
// octave, then presents the result from done once the output register is free.
// A two-entry queue takes new items while the back end works or waits.
// Reset clears queue, sequencer and output valid; octave_count resets to 4.
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves
// Fractal 2D gradient noise over a loaded permutation table.
// ----------------------------------------------------------------------------
module gradient_noise_2d_octaves (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gn2o_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [7:0]                          table_index,
	input  logic [7:0]                          table_value,
	input  logic [23:0]                         x_coord,
	input  logic [23:0]                         y_coord,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gn2o_pkg::OUT_W-1:0]   noise_value
);

	logic [gn2o_pkg::CFG_W-1:0] oct_cnt_q;
	gn2o_pkg::item_t            in_item;
	gn2o_pkg::queue_head_t      head;
	logic                       pop;

	// Hold the octave count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cnt_q <= gn2o_pkg::OCT_RESET;
		end else if (cfg_we) begin
			oct_cnt_q <= cfg_wdata;
		end
	end

	assign in_item.kind        = kind;
	assign in_item.table_index = table_index;
	assign in_item.table_value = table_value;
	assign in_item.x_coord     = x_coord;
	assign in_item.y_coord     = y_coord;

	gn2o_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.head    (head),
		.pop     (pop)
	);

	gn2o_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.oct_cnt    (oct_cnt_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.noise_value(noise_value)
	);

endmodule

FILE: sim/gradient_noise_2d_octaves_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves_test
// Fills the permutation table, then streams directed and random noise queries
// across several octave counts and idle/stall mixes. Each query is predicted
// in fixed point and compared with the block's output in order.
// ----------------------------------------------------------------------------
module gradient_noise_2d_octaves_test;

	// Predicted noise per query, plus a mirror of the table and octave count
	class noise_scoreboard;
		logic [7:0] perm [gn2o_pkg::TABLE_SIZE];
		int octaves;
		logic signed [gn2o_pkg::OUT_W-1:0] pending_noise [$];
		int mismatches;

		function new();
			octaves = gn2o_pkg::OCT_RESET;
			mismatches = 0;
		endfunction

		function longint fade(longint t);
			longint t2;
			longint inner;
			longint t3;
			t2 = (t * t) >>> gn2o_pkg::FRAC_BITS;
			inner = 10 * (longint'(1) << gn2o_pkg::FRAC_BITS) - 15 * t + 6 * t2;
			t3 = (t2 * t) >>> gn2o_pkg::FRAC_BITS;
			return (t3 * inner) >>> gn2o_pkg::FRAC_BITS;
		endfunction

		function longint blend(longint a, longint b, longint w);
			return a + (((b - a) * w) >>> gn2o_pkg::FRAC_BITS);
		endfunction

		function longint grad(logic [7:0] h, longint dx, longint dy);
			case (h[1:0])
				2'd0: return dx + dy;
				2'd1: return dy - dx;
				2'd2: return dx - dy;
				default: return -dx - dy;
			endcase
		endfunction

		function longint cell_noise(longint xs, longint ys);
			longint one;
			longint fx;
			longint fy;
			int xi;
			int yi;
			int xn;
			int yn;
			logic [7:0] px;
			logic [7:0] pxn;
			longint g1;
			longint g2;
			longint g3;
			longint g4;
			longint u;
			longint v;
			one = longint'(1) << gn2o_pkg::FRAC_BITS;
			xi = int'((xs >> gn2o_pkg::FRAC_BITS) % gn2o_pkg::TABLE_SIZE);
			yi = int'((ys >> gn2o_pkg::FRAC_BITS) % gn2o_pkg::TABLE_SIZE);
			xn = (xi + 1) % gn2o_pkg::TABLE_SIZE;
			yn = (yi + 1) % gn2o_pkg::TABLE_SIZE;
			fx = xs & (one - 1);
			fy = ys & (one - 1);
			px = perm[xi];
			pxn = perm[xn];
			g1 = grad(perm[(px + yi) % gn2o_pkg::TABLE_SIZE], fx, fy);
			g2 = grad(perm[(pxn + yi) % gn2o_pkg::TABLE_SIZE], fx - one, fy);
			g3 = grad(perm[(px + yn) % gn2o_pkg::TABLE_SIZE], fx, fy - one);
			g4 = grad(perm[(pxn + yn) % gn2o_pkg::TABLE_SIZE], fx - one, fy - one);
			u = fade(fx);
			v = fade(fy);
			return blend(blend(g1, g2, u), blend(g3, g4, u), v);
		endfunction

		// Note an accepted item: load updates the table, query queues a value
		function void note_input(logic k, logic [7:0] idx, logic [7:0] val,
			logic [23:0] x, logic [23:0] y);
			int n;
			longint sum;
			if (k == gn2o_pkg::KIND_LOAD) begin
				perm[idx] = val;
				return;
			end
			n = octaves;
			if (n < 1) n = 1;
			if (n > gn2o_pkg::MAX_OCTAVES) n = gn2o_pkg::MAX_OCTAVES;
			sum = 0;
			for (int i = 0; i < n; i++)
				sum += cell_noise(longint'(x) << i, longint'(y) << i) >>> i;
			pending_noise.push_back(sum[gn2o_pkg::OUT_W-1:0]);
		endfunction

		// Compare one result with the oldest prediction
		function void check_result(logic signed [gn2o_pkg::OUT_W-1:0] actual);
			logic signed [gn2o_pkg::OUT_W-1:0] want;
			if (pending_noise.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result noise_value=%0d", actual);
				return;
			end
			want = pending_noise.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("noise_value mismatch: expected %0d actual %0d", want, actual);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [gn2o_pkg::CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [7:0] table_index;
	logic [7:0] table_value;
	logic [23:0] x_coord;
	logic [23:0] y_coord;
	logic out_valid;
	logic out_stall;
	logic signed [gn2o_pkg::OUT_W-1:0] noise_value;

	noise_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;

	gradient_noise_2d_octaves uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.table_index(table_index),
		.table_value(table_value),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.noise_value(noise_value)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Randomly stall the output side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Record accepted items
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(kind, table_index, table_value, x_coord, y_coord);
	end

	// Check accepted results
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(noise_value);
	end

	// Present one item, hold it until accepted, then maybe idle
	task send_item(logic k, logic [7:0] idx, logic [7:0] val,
		logic [23:0] x, logic [23:0] y);
		in_valid <= 1'b1;
		kind <= k;
		table_index <= idx;
		table_value <= val;
		x_coord <= x;
		y_coord <= y;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
			@(posedge clk);
		end
	endtask

	task query(logic [23:0] x, logic [23:0] y);
		send_item(gn2o_pkg::KIND_EVAL, 8'($urandom_range(255)), 8'($urandom_range(255)),
			x, y);
	endtask

	// Wait until every prediction is met and the back end has gone quiet
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_noise.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task write_octaves(logic [gn2o_pkg::CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.octaves = v;
	endtask

	task random_item();
		logic [23:0] x;
		logic [23:0] y;
		int shape;
		shape = $urandom_range(99);
		x = 24'($urandom_range(24'hFFFFFF));
		y = 24'($urandom_range(24'hFFFFFF));
		if (shape < 20)
			send_item(gn2o_pkg::KIND_LOAD, 8'($urandom_range(255)),
				8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)),
				24'($urandom_range(24'hFFFFFF)));
		else if (shape < 28)
			query({x[23:16], 16'h0000}, {y[23:16], 16'h0000});
		else if (shape < 34)
			query({x[23:16], 16'hFFFF}, {y[23:16], 16'hFFFF});
		else
			query(x, y);
	endtask

	initial begin
		logic [gn2o_pkg::CFG_W-1:0] oct_plan [8];
		oct_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd4, 4'd7, 4'd5};
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = gn2o_pkg::KIND_LOAD;
		table_index = '0;
		table_value = '0;
		x_coord = '0;
		y_coord = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table so no query reads an unwritten entry
		for (int i = 0; i < gn2o_pkg::TABLE_SIZE; i++)
			send_item(gn2o_pkg::KIND_LOAD, i[7:0], 8'($urandom_range(255)), 24'h0, 24'h0);
		send_item(gn2o_pkg::KIND_LOAD, 8'd0, 8'd255, 24'hFFFFFF, 24'hFFFFFF);
		send_item(gn2o_pkg::KIND_LOAD, 8'd255, 8'd0, 24'h0, 24'h0);

		// Directed queries at the reset octave count
		query(24'h000000, 24'h000000);
		query(24'hFFFFFF, 24'hFFFFFF);
		query(24'h00FFFF, 24'h00FFFF);
		query(24'h010000, 24'h020000);
		query(24'hFF8000, 24'hFF8000);
		query(24'hFFFFFF, 24'h000000);
		query(24'h000000, 24'hFFFFFF);
		query(24'h008000, 24'h004000);
		query(24'h7FFFFF, 24'h800000);
		query(24'hAAAAAA, 24'h555555);
		query(24'h555555, 24'hAAAAAA);
		query(24'h000001, 24'h000001);
		drain();

		// Random phases over octave counts and idle/stall mixes
		for (int p = 0; p < 8; p++) begin
			write_octaves(oct_plan[p]);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 85; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 85; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			for (int n = 0; n < 41; n++)
				random_item();
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_noise.size() == 0)
			$display("gradient_noise_2d_octaves_test: PASS");
		else
			$display("gradient_noise_2d_octaves_test: FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin
		#20000000;
		$display("gradient_noise_2d_octaves_test: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gn2o_pkg.sv
rtl/gn2o_ram.sv
rtl/gn2o_front.sv
rtl/gn2o_back.sv
rtl/gradient_noise_2d_octaves.sv
sim/gradient_noise_2d_octaves_test.sv
